### rtl/tbcd_pkg.sv
// tbcd_pkg: shared types and constants for the text byte to code point decoder
// holds the encoding mode type, decode result struct and character constants
// no dependencies
package tbcd_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CpWidth    = 21;
   localparam int unsigned ModeWidth  = 2;
   localparam int unsigned RemWidth   = 2;
   localparam int unsigned UnitWidth  = 16;
   localparam int unsigned LowBitsW   = 10;

   typedef enum logic [ModeWidth-1:0] {
      MODE_UTF8   = 2'd0,
      MODE_U16BE  = 2'd1,
      MODE_U16LE  = 2'd2,
      MODE_RAW    = 2'd3
   } mode_type;

   localparam logic [CpWidth-1:0]   CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [CpWidth-1:0]   CP_SUPPLEMENT  = 21'h010000;
   localparam logic [UnitWidth-1:0] UNIT_HIGH_LO   = 16'hD800;
   localparam logic [UnitWidth-1:0] UNIT_LOW_LO    = 16'hDC00;
   localparam logic [UnitWidth-1:0] UNIT_LOW_END   = 16'hE000;
   localparam logic [ByteWidth-1:0] LEAD_ASCII_MAX = 8'h7F;
   localparam logic [ByteWidth-1:0] LEAD_TWO_MAX   = 8'hDF;
   localparam logic [ByteWidth-1:0] LEAD_THREE_MAX = 8'hEF;
   localparam logic [ByteWidth-1:0] LEAD_FOUR_MAX  = 8'hF4;

   typedef struct packed {
      logic               emit;
      logic [CpWidth-1:0] code_point;
      logic               replaced;
      logic               end_of_text;
   } dec_result_type;

endpackage

### rtl/text_byte_to_codepoint_decoder_core.sv
// text_byte_to_codepoint_decoder_core: top level of the byte to code point decoder
// input register, decode stage and result register with valid/stall handshakes
// depends on tbcd_pkg and tbcd_decode
//
// usage:
//   req_ channel carries one text byte per beat (req_valid / req_stall).
//   rsp_ channel carries one code point per beat with replaced and
//   end_of_text flags (rsp_valid / rsp_stall).
//   csr_ channel writes the 2-bit encoding mode (0 utf-8, 1 utf-16 be,
//   2 utf-16 le, 3 raw); csr_ready is always high and every write clears
//   the decoder state. write it only while no bytes are in flight.
//   an accepted byte is held in the input register and its result, if any,
//   is then registered in the result register that drives rsp_valid.
//   throughput is one byte per cycle while the result side is not stalled,
//   set by the single decode stage between the input and result registers.
//   bytes that complete nothing (lead bytes, first byte of a utf-16 unit,
//   high surrogates) give no result beat.
//   when rsp_stall is high the result holds; the input register drains only
//   if its byte gives no result, otherwise req_stall rises behind it.
//   reset empties both registers and selects utf-8 with no partial state.
module text_byte_to_codepoint_decoder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tbcd_pkg::ByteWidth-1:0]      req_in_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tbcd_pkg::CpWidth-1:0]        rsp_code_point,
   output logic                                rsp_replaced,
   output logic                                rsp_end_of_text,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tbcd_pkg::ModeWidth-1:0]      csr_encoding_mode
);
   import tbcd_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   logic [ByteWidth-1:0] s1_byte_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CpWidth-1:0]   rsp_cp_ff;
   logic                 rsp_rep_ff;
   logic                 rsp_eot_ff;

   dec_result_type       dec;
   logic                 out_free;
   logic                 s1_fire;
   logic                 req_accept;
   logic                 out_load;
   logic                 csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   tbcd_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_mode (csr_encoding_mode),
      .step     (s1_fire),
      .in_byte  (s1_byte_ff),
      .result   (dec)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      // a byte with no result can leave even while the output is held
      s1_fire      = s1_valid_ff && (out_free || !dec.emit);
      req_stall    = s1_valid_ff && !s1_fire;
      req_accept   = req_valid && !req_stall;
      out_load     = s1_fire && dec.emit;
      s1_valid_in  = req_accept | (s1_valid_ff & ~s1_fire);
      rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_in_byte;
      end
      if (out_load) begin
         rsp_cp_ff  <= dec.code_point;
         rsp_rep_ff <= dec.replaced;
         rsp_eot_ff <= dec.end_of_text;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code_point  = rsp_cp_ff;
   assign rsp_replaced    = rsp_rep_ff;
   assign rsp_end_of_text = rsp_eot_ff;

endmodule

### rtl/tbcd_decode.sv
// tbcd_decode: per-byte decode logic and decoder state for all encoding modes
// holds the mode register, utf-8 assembly state and utf-16 unit/surrogate state
// depends on tbcd_pkg
module tbcd_decode (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [tbcd_pkg::ModeWidth-1:0]      csr_mode,
   input  logic                                step,
   input  logic [tbcd_pkg::ByteWidth-1:0]      in_byte,
   output tbcd_pkg::dec_result_type            result
);
   import tbcd_pkg::*;

   mode_type             mode_ff;
   logic [RemWidth-1:0]  rem_ff,     rem_in;
   logic [CpWidth-1:0]   partial_ff, partial_in;
   logic                 phase_ff,   phase_in;
   logic [ByteWidth-1:0] held_ff,    held_in;
   logic                 hp_ff,      hp_in;
   logic [LowBitsW-1:0]  hb_ff,      hb_in;

   logic [RemWidth-1:0]  rem_dec;
   logic [CpWidth-1:0]   cont_bits;
   logic [UnitWidth-1:0] unit;
   logic [CpWidth-1:0]   pair_cp;

   always_comb begin
      rem_dec = rem_ff - 2'd1;
      case (rem_dec)
         2'd0:    cont_bits = {15'd0, in_byte[5:0]};
         2'd1:    cont_bits = {9'd0, in_byte[5:0], 6'd0};
         2'd2:    cont_bits = {3'd0, in_byte[5:0], 12'd0};
         default: cont_bits = {15'd0, in_byte[5:0]};
      endcase
      unit = (mode_ff == MODE_U16BE) ? {held_ff, in_byte} : {in_byte, held_ff};
      pair_cp = CP_SUPPLEMENT + {1'b0, hb_ff, unit[LowBitsW-1:0]};
   end

   always_comb begin
      result     = '0;
      rem_in     = rem_ff;
      partial_in = partial_ff;
      phase_in   = phase_ff;
      held_in    = held_ff;
      hp_in      = hp_ff;
      hb_in      = hb_ff;
      case (mode_ff)
         MODE_UTF8: begin
            if (rem_ff != '0) begin
               rem_in     = rem_dec;
               partial_in = partial_ff | cont_bits;
               if (rem_dec == '0) begin
                  result.emit       = 1'b1;
                  result.code_point = partial_ff | cont_bits;
                  partial_in        = '0;
               end
            end else if (in_byte == '0) begin
               result.emit        = 1'b1;
               result.end_of_text = 1'b1;
            end else if (in_byte <= LEAD_ASCII_MAX) begin
               result.emit       = 1'b1;
               result.code_point = {13'd0, in_byte};
            end else if (in_byte <= LEAD_TWO_MAX) begin
               partial_in = {10'd0, in_byte[4:0], 6'd0};
               rem_in     = 2'd1;
            end else if (in_byte <= LEAD_THREE_MAX) begin
               partial_in = {5'd0, in_byte[3:0], 12'd0};
               rem_in     = 2'd2;
            end else if (in_byte <= LEAD_FOUR_MAX) begin
               partial_in = {in_byte[2:0], 18'd0};
               rem_in     = 2'd3;
            end else begin
               result.emit       = 1'b1;
               result.code_point = CP_REPLACEMENT;
               result.replaced   = 1'b1;
            end
         end
         MODE_U16BE, MODE_U16LE: begin
            if (!phase_ff) begin
               held_in  = in_byte;
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (hp_ff) begin
                  hp_in       = 1'b0;
                  hb_in       = '0;
                  result.emit = 1'b1;
                  // a broken pair swallows the second unit
                  if (unit >= UNIT_LOW_LO && unit < UNIT_LOW_END) begin
                     result.code_point = pair_cp;
                  end else begin
                     result.code_point = CP_REPLACEMENT;
                     result.replaced   = 1'b1;
                  end
               end else if (unit < UNIT_HIGH_LO) begin
                  result.emit       = 1'b1;
                  result.code_point = {5'd0, unit};
               end else if (unit < UNIT_LOW_LO) begin
                  hp_in = 1'b1;
                  hb_in = unit[LowBitsW-1:0];
               end else if (unit < UNIT_LOW_END) begin
                  result.emit       = 1'b1;
                  result.code_point = CP_REPLACEMENT;
                  result.replaced   = 1'b1;
               end else begin
                  result.emit       = 1'b1;
                  result.code_point = {5'd0, unit};
               end
            end
         end
         default: begin
            result.emit        = 1'b1;
            result.code_point  = {13'd0, in_byte};
            result.end_of_text = (in_byte == '0);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_UTF8;
         rem_ff     <= '0;
         partial_ff <= '0;
         phase_ff   <= 1'b0;
         held_ff    <= '0;
         hp_ff      <= 1'b0;
         hb_ff      <= '0;
      end else if (csr_we) begin
         // a mode write drops any partial sequence
         mode_ff    <= mode_type'(csr_mode);
         rem_ff     <= '0;
         partial_ff <= '0;
         phase_ff   <= 1'b0;
         held_ff    <= '0;
         hp_ff      <= 1'b0;
         hb_ff      <= '0;
      end else if (step) begin
         rem_ff     <= rem_in;
         partial_ff <= partial_in;
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         hp_ff      <= hp_in;
         hb_ff      <= hb_in;
      end
   end

endmodule

### test/tb_text_byte_to_codepoint_decoder_core.sv
// tb_text_byte_to_codepoint_decoder_core: self-checking bench for the byte to code point decoder
// drives byte beats and mode writes, predicts each code point in step and checks every result beat
// depends on tbcd_pkg and text_byte_to_codepoint_decoder_core
module tb_text_byte_to_codepoint_decoder_core;
   import tbcd_pkg::*;

   localparam int DRAIN_CYCLES    = 4;
   localparam int QUIET_LIMIT     = 2000;
   localparam int SEGMENT_BYTES   = 100;
   localparam int MAX_REPORTS     = 10;
   localparam int LONG_HOLD       = 300;

   localparam int ASCII_LAST      = 'h7F;
   localparam int TWO_LEAD_LAST   = 'hDF;
   localparam int THREE_LEAD_LAST = 'hEF;
   localparam int FOUR_LEAD_LAST  = 'hF4;
   localparam int HIGH_SURR_FIRST = 'hD800;
   localparam int LOW_SURR_FIRST  = 'hDC00;
   localparam int LOW_SURR_LAST   = 'hDFFF;
   localparam int BMP_UPPER_FIRST = 'hE000;

   localparam logic [CpWidth-1:0] REPLACEMENT_CHAR = 21'h00FFFD;
   localparam logic [CpWidth-1:0] SUPPL_BASE       = 21'h010000;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               replaced;
      logic               end_of_text;
   } char_beat_type;

   logic                 clock;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_stall;
   logic [ByteWidth-1:0] req_in_byte       = '0;
   logic                 rsp_valid;
   logic                 rsp_stall         = 1'b0;
   logic [CpWidth-1:0]   rsp_code_point;
   logic                 rsp_replaced;
   logic                 rsp_end_of_text;
   logic                 csr_valid         = 1'b0;
   logic                 csr_ready;
   logic [ModeWidth-1:0] csr_encoding_mode = MODE_UTF8;

   // decoder copy kept in step with accepted bytes
   mode_type             cur_mode     = MODE_UTF8;
   logic [1:0]           cont_left    = '0;
   logic [CpWidth-1:0]   cp_accum     = '0;
   logic                 unit_half    = 1'b0;
   logic [ByteWidth-1:0] unit_first   = '0;
   logic                 high_held    = 1'b0;
   logic [9:0]           high_ten     = '0;

   char_beat_type        pending_chars[$];

   int tx_gap_pct      = 22;
   int rx_stall_pct    = 49;
   int rx_hold_request = 0;
   int quiet_cycles    = 0;
   int bytes_sent      = 0;
   int chars_checked   = 0;
   int replaced_seen   = 0;
   int eot_seen        = 0;
   int mode_writes     = 0;
   int mismatches      = 0;

   text_byte_to_codepoint_decoder_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_point    (rsp_code_point),
      .rsp_replaced      (rsp_replaced),
      .rsp_end_of_text   (rsp_end_of_text),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_encoding_mode (csr_encoding_mode)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void note_failure(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch %0d at %0t: %s", mismatches, $time, what);
      end
   endfunction

   function automatic void queue_char(input logic [CpWidth-1:0] cp, input logic bad,
                                      input logic eot);
      char_beat_type c;
      c.code_point  = cp;
      c.replaced    = bad;
      c.end_of_text = eot;
      pending_chars.push_back(c);
   endfunction

   function automatic void decode_byte(input logic [ByteWidth-1:0] b);
      logic [1:0]  left_next;
      logic [15:0] code_unit;
      case (cur_mode)
         MODE_UTF8: begin
            if (cont_left != 0) begin
               // continuation bits land below the lead bits, no marker check
               left_next = cont_left - 2'd1;
               cp_accum  = cp_accum | (CpWidth'(b[5:0]) << (6 * left_next));
               cont_left = left_next;
               if (left_next == 0) begin
                  queue_char(cp_accum, 1'b0, 1'b0);
                  cp_accum = '0;
               end
            end else if (b == 0) begin
               queue_char('0, 1'b0, 1'b1);
            end else if (b <= ASCII_LAST) begin
               queue_char(CpWidth'(b), 1'b0, 1'b0);
            end else if (b <= TWO_LEAD_LAST) begin
               cp_accum  = CpWidth'(b[4:0]) << 6;
               cont_left = 2'd1;
            end else if (b <= THREE_LEAD_LAST) begin
               cp_accum  = CpWidth'(b[3:0]) << 12;
               cont_left = 2'd2;
            end else if (b <= FOUR_LEAD_LAST) begin
               cp_accum  = CpWidth'(b[2:0]) << 18;
               cont_left = 2'd3;
            end else begin
               queue_char(REPLACEMENT_CHAR, 1'b1, 1'b0);
            end
         end
         MODE_RAW: begin
            queue_char(CpWidth'(b), 1'b0, b == 0);
         end
         default: begin
            if (!unit_half) begin
               unit_first = b;
               unit_half  = 1'b1;
            end else begin
               unit_half = 1'b0;
               code_unit = (cur_mode == MODE_U16BE) ? {unit_first, b} : {b, unit_first};
               if (high_held) begin
                  // the partner is consumed either way, a bad one is not decoded alone
                  high_held = 1'b0;
                  if (code_unit >= LOW_SURR_FIRST && code_unit <= LOW_SURR_LAST) begin
                     queue_char(SUPPL_BASE + CpWidth'({high_ten, code_unit[9:0]}), 1'b0, 1'b0);
                  end else begin
                     queue_char(REPLACEMENT_CHAR, 1'b1, 1'b0);
                  end
                  high_ten = '0;
               end else if (code_unit < HIGH_SURR_FIRST) begin
                  queue_char(CpWidth'(code_unit), 1'b0, 1'b0);
               end else if (code_unit < LOW_SURR_FIRST) begin
                  high_held = 1'b1;
                  high_ten  = code_unit[9:0];
               end else if (code_unit < BMP_UPPER_FIRST) begin
                  queue_char(REPLACEMENT_CHAR, 1'b1, 1'b0);
               end else begin
                  queue_char(CpWidth'(code_unit), 1'b0, 1'b0);
               end
            end
         end
      endcase
   endfunction

   task automatic check_char();
      char_beat_type want;
      if (pending_chars.size() == 0) begin
         note_failure($sformatf("result beat cp %h with nothing expected", rsp_code_point));
      end else begin
         want = pending_chars.pop_front();
         chars_checked++;
         if (want.replaced) replaced_seen++;
         if (want.end_of_text) eot_seen++;
         if (rsp_code_point !== want.code_point || rsp_replaced !== want.replaced ||
             rsp_end_of_text !== want.end_of_text) begin
            note_failure($sformatf("expected cp %h repl %b eot %b, got cp %h repl %b eot %b",
                                   want.code_point, want.replaced, want.end_of_text,
                                   rsp_code_point, rsp_replaced, rsp_end_of_text));
         end
      end
   endtask

   // result side: random stall, or a counted hold-off when one is requested
   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rx_hold_request > 0) begin
            hold_left       = rx_hold_request;
            rx_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_stall_pct);
         end
      end
   end

   initial begin : result_check
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (!reset && rsp_valid && !rsp_stall) check_char();
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // valid stays high on return so back-to-back beats need no extra edge
   task automatic send_byte(input logic [ByteWidth-1:0] b);
      while ($urandom_range(99) < tx_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      decode_byte(b);
      bytes_sent++;
   endtask

   task automatic send_code_unit(input logic [15:0] u);
      if (cur_mode == MODE_U16BE) begin
         send_byte(u[15:8]);
         send_byte(u[7:0]);
      end else begin
         send_byte(u[7:0]);
         send_byte(u[15:8]);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_chars.size() != 0);
   endtask

   task automatic set_mode(input mode_type m);
      wait_drained();
      // a lead or half unit may still sit in the pipe with no result behind it
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_encoding_mode <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_mode   = m;
      cont_left  = '0;
      cp_accum   = '0;
      unit_half  = 1'b0;
      unit_first = '0;
      high_held  = 1'b0;
      high_ten   = '0;
      mode_writes++;
   endtask

   task automatic random_text(input int n);
      int                   start;
      int                   sel;
      int                   len;
      logic [ByteWidth-1:0] lead;
      start = bytes_sent;
      while (bytes_sent - start < n) begin
         sel = $urandom_range(99);
         case (cur_mode)
            MODE_UTF8: begin
               if (sel < 80) begin
                  len = $urandom_range(1, 4);
                  case (len)
                     1:       lead = 8'($urandom_range(0, ASCII_LAST));
                     2:       lead = 8'($urandom_range('h80, TWO_LEAD_LAST));
                     3:       lead = 8'($urandom_range(TWO_LEAD_LAST + 1, THREE_LEAD_LAST));
                     default: lead = 8'($urandom_range(THREE_LEAD_LAST + 1, FOUR_LEAD_LAST));
                  endcase
                  send_byte(lead);
                  // mostly proper continuations, now and then any byte at all
                  repeat (len - 1)
                     send_byte($urandom_range(9) ? {2'b10, 6'($urandom)} : 8'($urandom));
               end else begin
                  send_byte(8'($urandom));
               end
            end
            MODE_RAW: begin
               send_byte(sel < 5 ? 8'h00 : 8'($urandom));
            end
            default: begin
               if (sel < 55) begin
                  send_code_unit(16'($urandom_range(1) ? $urandom_range(BMP_UPPER_FIRST, 'hFFFF)
                                                       : $urandom_range(0, HIGH_SURR_FIRST - 1)));
               end else if (sel < 80) begin
                  send_code_unit(16'(HIGH_SURR_FIRST + $urandom_range(0, 'h3FF)));
                  send_code_unit(16'(LOW_SURR_FIRST + $urandom_range(0, 'h3FF)));
               end else if (sel < 90) begin
                  send_code_unit(16'(LOW_SURR_FIRST + $urandom_range(0, 'h3FF)));
               end else if (sel < 95) begin
                  send_code_unit(16'(HIGH_SURR_FIRST + $urandom_range(0, 'h3FF)));
                  send_code_unit(16'($urandom));
               end else begin
                  // lone byte shifts the unit boundary
                  send_byte(8'($urandom));
               end
            end
         endcase
      end
   endtask

   task automatic test_utf8_directed();
      // end marker, ascii top, two-byte, stray continuation as lead,
      // F4 lead to the largest unchecked value, bad leads, zero continuation
      logic [ByteWidth-1:0] seq [14] = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'h80, 8'hBF,
                                          8'hF4, 8'hBF, 8'hBF, 8'hBF, 8'hF5, 8'hFF,
                                          8'hC3, 8'h00};
      foreach (seq[i]) send_byte(seq[i]);
      wait_drained();
   endtask

   task automatic test_mode_switch_discard();
      send_byte(8'hE2);
      send_byte(8'h82);
      set_mode(MODE_U16BE);
   endtask

   task automatic test_utf16_directed();
      // zero unit, surrogate pair, lone low, high followed by a plain unit
      logic [ByteWidth-1:0] seq [12] = '{8'h00, 8'h00, 8'hD8, 8'h3D, 8'hDE, 8'h00,
                                          8'hDC, 8'h00, 8'hDB, 8'hFF, 8'h00, 8'h41};
      foreach (seq[i]) send_byte(seq[i]);
      send_byte(8'hD8);
      set_mode(MODE_U16LE);
   endtask

   task automatic test_raw_directed();
      set_mode(MODE_RAW);
      send_byte(8'h00);
      send_byte(8'hFF);
      wait_drained();
   endtask

   task automatic test_random_streams();
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               tx_gap_pct   = 22;
               rx_stall_pct = 49;
            end
            1: begin
               tx_gap_pct   = 49;
               rx_stall_pct = 22;
            end
            default: begin
               tx_gap_pct   = 0;
               rx_stall_pct = 0;
            end
         endcase
         for (int k = 0; k < 4; k++) begin
            set_mode(mode_type'(2'((k + ph) % 4)));
            random_text(SEGMENT_BYTES);
         end
      end
   endtask

   task automatic test_backpressure();
      set_mode(MODE_RAW);
      rx_hold_request = LONG_HOLD;
      repeat (40) send_byte(8'($urandom_range(1, 255)));
      wait_drained();
   endtask

   task automatic test_burst_pause();
      set_mode(MODE_UTF8);
      random_text(30);
      wait_drained();
      random_text(30);
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_utf8_directed();
      test_mode_switch_discard();
      test_utf16_directed();
      test_raw_directed();
      test_random_streams();
      test_backpressure();
      test_burst_pause();
      wait_drained();
      repeat (DRAIN_CYCLES + 4) @(posedge clock);
      $display("sent %0d bytes across %0d mode writes in all four encodings", bytes_sent,
               mode_writes);
      $display("checked %0d code points: %0d replacements, %0d end markers, %0d mismatches",
               chars_checked, replaced_seen, eot_seen, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
